// ----- src/bnt_pkg.sv -----
// ----------------------------------------------------------------------------
// bnt_pkg
// Shared types and constants of the beacon neighbor table.
// ----------------------------------------------------------------------------
package bnt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ROLE_AP  = 2'd0;
    localparam logic [1:0] ROLE_STA = 2'd1;

    // register indexes of the configuration port
    localparam logic REG_MARGIN = 1'b0;
    localparam logic REG_AGE    = 1'b1;

    typedef enum logic [1:0] {
        KIND_BEACON = 2'd0,
        KIND_SWEEP  = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_UNUSED = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_ADDED    = 3'd1,
        ST_REPLACED = 3'd2,
        ST_WEAK     = 3'd3,
        ST_REJECTED = 3'd4,
        ST_SWEPT    = 3'd5,
        ST_BEST     = 3'd6,
        ST_NONE     = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_WRITE,
        S_READ
    } t_state;

    typedef struct packed {
        logic [7:0]  tail;
        logic [63:0] w3;
        logic [63:0] w2;
        logic [63:0] w1;
        logic [63:0] w0;
    } t_ssid;

    // item held stable while it walks the chain
    typedef struct packed {
        t_kind       kind;
        t_ssid       ssid;
        logic [1:0]  role;
        logic [7:0]  rssi;
        logic [47:0] mac;
        logic [7:0]  link;
        logic [31:0] now;
    } t_item;

    // search accumulators handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic [8:0]        weak_str;
        logic [SLOT_W-1:0] weak_slot;
        logic              found;
        logic [7:0]        best_str;
        logic [SLOT_W-1:0] best_slot;
    } t_token;

    typedef struct packed {
        logic              en;
        logic              fresh;   // slot newly taken: clear before write
        logic [SLOT_W-1:0] slot;
    } t_wr_cmd;

    typedef struct packed {
        t_ssid      ssid;
        logic [7:0] peak_ap;
        logic [7:0] peak_cpe;
    } t_view;

endpackage

// ----- src/bnt_cell.sv -----
// ----------------------------------------------------------------------------
// bnt_cell
// One table slot. Acts on the search token as it passes and forwards it.
// ----------------------------------------------------------------------------
module bnt_cell import bnt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_index,
    input  logic [CNT_W-1:0]  i_used,
    input  logic [15:0]       i_age_limit,
    input  t_item             i_item,
    input  t_token            i_tok,
    input  t_wr_cmd           i_wr,
    output t_token            o_tok,
    output t_view             o_view
);

    t_ssid       r_ssid,      n_ssid;
    logic [7:0]  r_peak_ap,   n_peak_ap;
    logic [7:0]  r_peak_cpe,  n_peak_cpe;
    logic [1:0]  r_seen,      n_seen;
    logic [31:0] r_stamp_ap,  n_stamp_ap;
    logic [31:0] r_stamp_cpe, n_stamp_cpe;
    logic [47:0] r_mac,       n_mac;
    logic [7:0]  r_link,      n_link;
    t_token      r_tok,       n_tok;

    logic        active;
    logic [7:0]  strength;
    logic [32:0] da, dc;
    logic        stale;
    logic        cand;

    always_comb begin
        active   = CNT_W'(i_index) < i_used;
        strength = (r_peak_ap >= r_peak_cpe) ? r_peak_ap : r_peak_cpe;
        da       = {1'b0, i_item.now} - {1'b0, r_stamp_ap};
        dc       = {1'b0, i_item.now} - {1'b0, r_stamp_cpe};
        // negative difference (stamp in the future) never ages out
        stale    = ((r_stamp_ap != '0) || (r_stamp_cpe != '0))
                   && !da[32] && (da[31:0] >= {16'd0, i_age_limit})
                   && !dc[32] && (dc[31:0] >= {16'd0, i_age_limit});
        cand     = (r_seen[0] && (i_item.role == ROLE_STA))
                   || (!r_seen[0] && r_seen[1] && (i_item.role == ROLE_AP));
    end

    always_comb begin
        n_tok       = i_tok;
        n_ssid      = r_ssid;
        n_peak_ap   = r_peak_ap;
        n_peak_cpe  = r_peak_cpe;
        n_seen      = r_seen;
        n_stamp_ap  = r_stamp_ap;
        n_stamp_cpe = r_stamp_cpe;
        n_mac       = r_mac;
        n_link      = r_link;

        if (i_tok.valid) begin
            if ({1'b0, strength} < i_tok.weak_str) begin
                n_tok.weak_str  = {1'b0, strength};
                n_tok.weak_slot = i_index;
            end
            if ((i_item.kind == KIND_QUERY) && active && cand
                    && (strength > i_tok.best_str)) begin
                n_tok.best_str  = strength;
                n_tok.best_slot = i_index;
                n_tok.found     = 1'b1;
            end
            if ((i_item.kind == KIND_SWEEP) && active && stale) begin
                n_ssid      = '0;
                n_peak_ap   = '0;
                n_peak_cpe  = '0;
                n_seen      = '0;
                n_stamp_ap  = '0;
                n_stamp_cpe = '0;
                n_mac       = '0;
                n_link      = '0;
            end
            if ((i_item.kind == KIND_BEACON) && active && !i_tok.hit
                    && (r_ssid == i_item.ssid)) begin
                n_tok.hit      = 1'b1;
                n_tok.hit_slot = i_index;
                if (i_item.role == ROLE_AP) begin
                    if (i_item.rssi > r_peak_ap) begin
                        n_peak_ap = i_item.rssi;
                    end else if (r_peak_ap != '0) begin
                        n_peak_ap = r_peak_ap - 8'd1;
                    end
                    n_seen[0]  = 1'b1;
                    n_stamp_ap = i_item.now;
                end else begin
                    n_seen[1] = 1'b1;
                    if (i_item.rssi >= r_peak_cpe) begin
                        n_peak_cpe = i_item.rssi;
                        n_mac      = i_item.mac;
                    end else if (r_peak_cpe != '0) begin
                        n_peak_cpe = r_peak_cpe - 8'd1;
                    end
                    n_stamp_cpe = i_item.now;
                    n_link      = i_item.link;
                end
            end
        end

        if (i_wr.en && (i_wr.slot == i_index)) begin
            if (i_wr.fresh) begin
                n_peak_ap   = '0;
                n_peak_cpe  = '0;
                n_seen      = '0;
                n_stamp_ap  = '0;
                n_stamp_cpe = '0;
                n_mac       = '0;
                n_link      = '0;
            end
            n_ssid = i_item.ssid;
            if (i_item.role == ROLE_AP) begin
                n_peak_ap  = i_item.rssi;
                n_seen[0]  = 1'b1;
                n_stamp_ap = i_item.now;
            end else begin
                n_peak_cpe  = i_item.rssi;
                n_seen[1]   = 1'b1;
                n_stamp_cpe = i_item.now;
                n_mac       = i_item.mac;
                n_link      = i_item.link;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ssid      <= n_ssid;
        r_peak_ap   <= n_peak_ap;
        r_peak_cpe  <= n_peak_cpe;
        r_seen      <= n_seen;
        r_stamp_ap  <= n_stamp_ap;
        r_stamp_cpe <= n_stamp_cpe;
        r_mac       <= n_mac;
        r_link      <= n_link;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok           = r_tok;
    assign o_view.ssid     = r_ssid;
    assign o_view.peak_ap  = r_peak_ap;
    assign o_view.peak_cpe = r_peak_cpe;

endmodule

// ----- src/beacon_neighbor_table.sv -----
// ----------------------------------------------------------------------------
// beacon_neighbor_table
// Neighbor network table built from beacons, with aging and best-pick query.
// ----------------------------------------------------------------------------
// A search token walks the row of TABLE_DEPTH slot cells, one cell per cycle,
// matching, aging and ranking in place, then an optional write state and a read
// state, which waits for the output to be free, finish the item; a rejected
// item goes straight to the read state. One item is in flight at a time. Slot
// contents are undefined after reset until a slot is taken.
module beacon_neighbor_table import bnt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // ssid_word0..3, ssid_tail, role, rssi, sender_mac, link_status,
    // now_seconds, zero pad
    input  logic [367:0] i_s_tdata,
    // kind
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // slot, best_ssid_word0..3, best_ssid_tail, entry_rssi_ap,
    // entry_rssi_cpe, zero pad
    output logic [287:0] o_m_tdata,
    // status
    output logic [2:0]   o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    t_state            r_state, n_state;
    t_item             r_item, w_in_item;
    logic [CNT_W-1:0]  r_used;
    logic [7:0]        r_margin;
    logic [15:0]       r_age;
    logic              r_launch;
    t_status           r_status;
    logic [SLOT_W-1:0] r_slot;
    logic              r_fresh;
    logic              r_m_valid;
    logic [287:0]      r_m_tdata, n_m_tdata;
    logic [2:0]        r_m_tuser;

    t_token  w_tok [TABLE_DEPTH+1];
    t_view   w_view [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_tok_valid;
    t_wr_cmd w_wr;

    logic    accept, walk_ok, load_out, end_walk;
    t_status dec_status;
    logic [SLOT_W-1:0] dec_slot;
    logic    dec_write;
    logic [8:0] diff;
    t_view   sel;

    always_comb begin
        w_in_item.kind      = t_kind'(i_s_tuser);
        w_in_item.ssid.w0   = i_s_tdata[63:0];
        w_in_item.ssid.w1   = i_s_tdata[127:64];
        w_in_item.ssid.w2   = i_s_tdata[191:128];
        w_in_item.ssid.w3   = i_s_tdata[255:192];
        w_in_item.ssid.tail = i_s_tdata[263:256];
        w_in_item.role      = i_s_tdata[265:264];
        w_in_item.rssi      = i_s_tdata[273:266];
        w_in_item.mac       = i_s_tdata[321:274];
        w_in_item.link      = i_s_tdata[329:322];
        w_in_item.now       = i_s_tdata[361:330];
        walk_ok = (w_in_item.kind == KIND_SWEEP) || (w_in_item.kind == KIND_QUERY)
                  || ((w_in_item.kind == KIND_BEACON) && (w_in_item.ssid.w0[7:0] != '0)
                      && (w_in_item.rssi != '0) && !w_in_item.role[1]);
    end

    always_comb begin
        w_tok[0]           = '0;
        w_tok[0].valid     = r_launch;
        w_tok[0].weak_str  = 9'h100;
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            bnt_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_index     (SLOT_W'(gi)),
                .i_used      (r_used),
                .i_age_limit (r_age),
                .i_item      (r_item),
                .i_tok       (w_tok[gi]),
                .i_wr        (w_wr),
                .o_tok       (w_tok[gi+1]),
                .o_view      (w_view[gi])
            );
            assign w_tok_valid[gi] = w_tok[gi+1].valid;
        end
    endgenerate

    // decision at the end of the walk
    always_comb begin
        t_token t;
        t = w_tok[TABLE_DEPTH];
        end_walk   = t.valid;
        diff       = {1'b0, r_item.rssi} - t.weak_str;
        dec_write  = 1'b0;
        dec_slot   = '0;
        dec_status = ST_NONE;
        unique case (r_item.kind)
            KIND_SWEEP: dec_status = ST_SWEPT;
            KIND_QUERY: begin
                dec_status = t.found ? ST_BEST : ST_NONE;
                dec_slot   = t.found ? t.best_slot : '0;
            end
            default: begin
                if (t.hit) begin
                    dec_status = ST_UPDATED;
                    dec_slot   = t.hit_slot;
                end else if (r_used < CNT_W'(TABLE_DEPTH)) begin
                    dec_status = ST_ADDED;
                    dec_slot   = r_used[SLOT_W-1:0];
                    dec_write  = 1'b1;
                end else if (({1'b0, r_item.rssi} >= t.weak_str)
                             && (diff >= {1'b0, r_margin})) begin
                    dec_status = ST_REPLACED;
                    dec_slot   = t.weak_slot;
                    dec_write  = 1'b1;
                end else begin
                    dec_status = ST_WEAK;
                    dec_slot   = t.weak_slot;
                end
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_s_tvalid) n_state = walk_ok ? S_WALK : S_READ;
            S_WALK:  if (end_walk) n_state = dec_write ? S_WRITE : S_READ;
            S_WRITE: n_state = S_READ;
            S_READ:  if (!r_m_valid || i_m_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = (r_state == S_IDLE);
        accept     = o_s_tready && i_s_tvalid;
        load_out   = (r_state == S_READ) && (!r_m_valid || i_m_tready);
        w_wr.en    = (r_state == S_WRITE);
        w_wr.fresh = r_fresh;
        w_wr.slot  = r_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        sel = w_view[r_slot];
    end

    // result payload
    always_comb begin
        n_m_tdata      = '0;
        n_m_tdata[3:0] = 4'(r_slot);
        if (r_status == ST_BEST) begin
            n_m_tdata[67:4]    = sel.ssid.w0;
            n_m_tdata[131:68]  = sel.ssid.w1;
            n_m_tdata[195:132] = sel.ssid.w2;
            n_m_tdata[259:196] = sel.ssid.w3;
            n_m_tdata[267:260] = sel.ssid.tail;
        end
        if ((r_status != ST_REJECTED) && (r_status != ST_SWEPT)
                && (r_status != ST_NONE)) begin
            n_m_tdata[275:268] = sel.peak_ap;
            n_m_tdata[283:276] = sel.peak_cpe;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_margin  <= 8'd10;
            r_age     <= 16'd60;
            r_launch  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_launch <= accept && walk_ok;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_MARGIN: r_margin <= i_cfg_data[7:0];
                    REG_AGE:    r_age    <= i_cfg_data;
                    default:    ;
                endcase
            end
            if (end_walk && (dec_status == ST_ADDED)) begin
                r_used <= r_used + CNT_W'(1);
            end
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item   <= w_in_item;
            r_status <= ST_REJECTED;
            r_slot   <= '0;
        end
        if (end_walk) begin
            r_status <= dec_status;
            r_slot   <= dec_slot;
            r_fresh  <= (dec_status == ST_ADDED);
        end
        if (load_out) begin
            r_m_tuser <= r_status;
            r_m_tdata <= n_m_tdata;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_tdata;
    assign o_m_tuser   = r_m_tuser;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_DEPTH))
        else $error("slot count exceeds table depth");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_tok_valid, r_launch}) <= 1)
        else $error("more than one search token in the chain");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (w_tok_valid == '0) && !r_launch)
        else $error("input ready while a search is in flight");

    a_write_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> (r_state == S_READ))
        else $error("slot write not followed by result read");
`endif

endmodule
